// ----- rtl/core/isr_pkg.sv -----
package isr_pkg;

    // Width of the radicand and of the root.
    localparam int INPUT_BITS = 32;
    localparam int ROOT_BITS  = (INPUT_BITS + 1) / 2;

    // The radicand is padded to an even width so that each cell takes two bits.
    localparam int PAD_BITS   = 2 * ROOT_BITS;

    // The partial remainder stays below twice the partial root plus one.
    localparam int REM_BITS   = ROOT_BITS + 2;

    // Data handed from one cell to the next.
    typedef struct packed {
        logic                vld;
        logic                zero;
        logic [PAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } t_cell;

endpackage

// ----- rtl/core/integer_square_root_floor_unit.sv -----
// A transaction accepted at the input passes through the chain of registered cells, one
// cell per root bit, and its root is shown at the output of the last cell, where it is
// taken when the output is not stalled.
// Throughput: one transaction per cycle while the output is not stalled; the whole
// chain of cells advances together and holds when the result waits.
// Reset: synchronous, active low; it clears the valid bit of every cell.
module integer_square_root_floor_unit
    import isr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [INPUT_BITS-1:0] i_radicand,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ROOT_BITS-1:0]  o_root
);

    t_cell w_link [0:ROOT_BITS];
    logic  w_adv;

    // The chain moves when its last cell is empty or its result is taken.
    assign w_adv   = !w_link[ROOT_BITS].vld || !i_stall;
    assign o_stall = !w_adv;

    // Load the first cell with the padded radicand and cleared partial results.
    always_comb begin
        w_link[0].vld  = i_valid;
        w_link[0].zero = (i_radicand == '0);
        w_link[0].rad  = PAD_BITS'(i_radicand);
        w_link[0].rem  = '0;
        w_link[0].root = '0;
    end

    // One cell per root bit, most significant first.
    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
        isr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_d     (w_link[g]),
            .o_q     (w_link[g+1])
        );
    end

    // A zero radicand reports a root of one; its computed root is zero.
    assign o_valid = w_link[ROOT_BITS].vld;
    assign o_root  = w_link[ROOT_BITS].root | ROOT_BITS'(w_link[ROOT_BITS].zero);

endmodule

// ----- rtl/core/isr_cell.sv -----
module isr_cell
    import isr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  t_cell i_d,
    output t_cell o_q
);

    logic [REM_BITS+1:0]  w_cat;
    logic [REM_BITS+1:0]  w_trial;
    logic [REM_BITS+1:0]  w_diff;
    logic                 w_ge;
    t_cell                n_q;
    logic                 r_vld;
    t_cell                r_pay;

    // One digit step: bring down two radicand bits and try the next root bit.
    assign w_cat   = {i_d.rem, i_d.rad[PAD_BITS-1 -: 2]};
    assign w_trial = (REM_BITS + 2)'({i_d.root, 2'b01});
    assign w_ge    = (w_cat >= w_trial);
    assign w_diff  = w_cat - w_trial;

    always_comb begin
        n_q      = i_d;
        n_q.rad  = i_d.rad << 2;
        n_q.rem  = w_ge ? REM_BITS'(w_diff) : REM_BITS'(w_cat);
        n_q.root = ROOT_BITS'({i_d.root, w_ge});
    end

    // The valid bit is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_d.vld;
        end
    end

    // The payload moves whenever the chain advances.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pay <= n_q;
        end
    end

    always_comb begin
        o_q     = r_pay;
        o_q.vld = r_vld;
    end

endmodule

// ----- rtl/core/isr_checker.sv -----
module isr_checker
    import isr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic [INPUT_BITS-1:0] i_radicand,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [ROOT_BITS-1:0]  o_root
);

    // A delivered root is never zero.
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_root != '0))
        else $error("root of zero delivered");

    // The input is held back exactly when a finished result is waiting.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not match output backpressure");

    // A stalled result stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_root)))
        else $error("stalled result changed");

    // Reset empties the chain.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind integer_square_root_floor_unit isr_checker u_isr_checker (.*);
